### src/scan_point_distance_resampler_unit_macros.svh
// Assertion macros for the scan point distance resampler.
// Depends on nothing; the using module must have signals clk and rst_n.
`ifndef SCAN_POINT_DISTANCE_RESAMPLER_UNIT_MACROS_SVH
`define SCAN_POINT_DISTANCE_RESAMPLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spdr assertion failed");
`define SPDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spdr assertion failed");
`else
`define SPDR_ASSERT(lbl, prop)
`define SPDR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/spdr_pkg.sv
// Shared types and constants of the scan point distance resampler.
// Depends on nothing.
package spdr_pkg;

  localparam int CW         = 32;
  localparam int TAG_W      = 8;
  localparam int REG_W      = 31;
  localparam int MAX_RUN    = 64;
  localparam int RUN_W      = $clog2(MAX_RUN + 1);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int QDEPTH     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 1'b1;

  localparam logic [REG_W-1:0] MIN_SPACING_RESET = 31'd3277;
  localparam logic [REG_W-1:0] MAX_GAP_RESET     = 31'd16384;
  localparam logic [CW-1:0]    LEN_SAT           = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [TAG_W-1:0]     tag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [TAG_W-1:0]     tag;
    logic                 interp;
    logic                 last;
    logic                 trunc;
  } result_t;

endpackage

### src/spdr_front.sv
// Input side of the resampler: accepts items and queues them for the engine.
// Depends on spdr_pkg.
module spdr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spdr_pkg::item_t     in_item,
  output spdr_pkg::queue_head_t head,
  input  logic                pop
);

  spdr_pkg::item_t q_r [spdr_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, do_pop;

  assign in_ready = (count_r != 2'(spdr_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

### src/spdr_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on spdr_pkg.
module spdr_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [63:0]              radicand,
  output logic                     done,
  output logic [spdr_pkg::CW-1:0]  root
);

  localparam int CNT_W = $clog2(spdr_pkg::SQRT_STEPS + 1);

  logic [63:0]      v_r, v_nxt, r_r, r_nxt, b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0]      trial;

  assign trial = r_r + b_r;
  assign done  = done_r;
  assign root  = r_r[spdr_pkg::CW-1:0];

  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = radicand;
      r_nxt    = 64'd0;
      b_nxt    = 64'd1 << 62;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt   = b_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(spdr_pkg::SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

endmodule

### src/spdr_div.sv
// Restoring divider, one quotient bit per cycle; the quotient must fit 32 bits.
// Depends on spdr_pkg.
module spdr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [62:0]              dividend,
  input  logic [spdr_pkg::CW-1:0]  divisor,
  output logic                     done,
  output logic [spdr_pkg::CW-1:0]  quotient
);

  localparam int CNT_W = $clog2(spdr_pkg::DIV_STEPS + 1);

  logic [31:0]      rem_r, rem_nxt, lo_r, lo_nxt, q_r, q_nxt, dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0]      trial;

  assign trial    = {rem_r, lo_r[31]};
  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend[62:32]};
      lo_nxt   = dividend[31:0];
      q_nxt    = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      lo_nxt = {lo_r[30:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(spdr_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

### src/spdr_back.sv
// Resampling engine: measures, decides, interpolates and drives the result register.
// Depends on spdr_pkg, spdr_sqrt, spdr_div and the assertion macro header.
`include "scan_point_distance_resampler_unit_macros.svh"
module spdr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spdr_pkg::queue_head_t        head,
  output logic                         pop,
  input  logic [spdr_pkg::REG_W-1:0]   min_spacing,
  input  logic [spdr_pkg::REG_W-1:0]   max_gap,
  output logic                         out_valid,
  input  logic                         out_ready,
  output spdr_pkg::result_t            out_res
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DIFF   = 11'b000_0000_0010,
    S_SQX    = 11'b000_0000_0100,
    S_SQY    = 11'b000_0000_1000,
    S_SQS    = 11'b000_0001_0000,
    S_SQRT   = 11'b000_0010_0000,
    S_DECIDE = 11'b000_0100_0000,
    S_FLUSH  = 11'b000_1000_0000,
    S_ACT    = 11'b001_0000_0000,
    S_MULI   = 11'b010_0000_0000,
    S_DIV    = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    OC_DROP   = 2'd0,
    OC_COPY   = 2'd1,
    OC_TRUNC  = 2'd2,
    OC_INTERP = 2'd3
  } outcome_t;

  localparam int CW = spdr_pkg::CW;

  state_t   state_r, state_nxt;
  outcome_t outcome_r, outcome_nxt;

  logic signed [CW-1:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt, prev_x_nxt, prev_y_nxt;
  logic [spdr_pkg::TAG_W-1:0] cur_tag_r, cur_tag_nxt;
  logic [spdr_pkg::REG_W-1:0] acc_r, acc_nxt, rem_r, rem_nxt;
  logic [CW-1:0]  ax_r, ay_r, ax_nxt, ay_nxt, len_r, len_nxt;
  logic           negx_r, negy_r, negx_nxt, negy_nxt, sat_r, sat_nxt;
  logic [61:0]    sqx_r, sqy_r, sqx_nxt, sqy_nxt, prx_r, pry_r, prx_nxt, pry_nxt;
  logic [spdr_pkg::RUN_W-1:0] run_n_r, run_n_nxt;
  spdr_pkg::result_t pend_r, pend_nxt, out_r, out_nxt;
  logic           pend_valid_r, pend_valid_nxt, out_valid_r, out_valid_nxt;

  logic           out_free;
  logic [CW:0]    dx, dy, mx, my, total;
  logic           sq_done, dvx_done, dvy_done, div_start;
  logic [CW-1:0]  sq_root, qx, qy;
  logic [62:0]    dvd_x, dvd_y;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign pop       = (state_r == S_IDLE) && head.valid;

  assign dx    = {cur_x_r[CW-1], cur_x_r} - {prev_x_r[CW-1], prev_x_r};
  assign dy    = {cur_y_r[CW-1], cur_y_r} - {prev_y_r[CW-1], prev_y_r};
  assign mx    = dx[CW] ? -dx : dx;
  assign my    = dy[CW] ? -dy : dy;
  assign total = {2'b00, acc_r} + {1'b0, len_r};
  assign dvd_x = {1'b0, prx_r} + 63'(len_r >> 1);
  assign dvd_y = {1'b0, pry_r} + 63'(len_r >> 1);
  assign div_start = (state_r == S_MULI);

  spdr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_SQS),
    .radicand({2'b00, sqx_r} + {2'b00, sqy_r}), .done(sq_done), .root(sq_root)
  );

  spdr_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_x),
    .divisor(len_r), .done(dvx_done), .quotient(qx)
  );

  spdr_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_y),
    .divisor(len_r), .done(dvy_done), .quotient(qy)
  );

  always_comb begin
    state_nxt      = state_r;
    outcome_nxt    = outcome_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cur_tag_nxt    = cur_tag_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    negx_nxt       = negx_r;
    negy_nxt       = negy_r;
    sat_nxt        = sat_r;
    len_nxt        = len_r;
    sqx_nxt        = sqx_r;
    sqy_nxt        = sqy_r;
    prx_nxt        = prx_r;
    pry_nxt        = pry_r;
    run_n_nxt      = run_n_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          cur_x_nxt   = head.item.x;
          cur_y_nxt   = head.item.y;
          cur_tag_nxt = head.item.tag;
          run_n_nxt   = '0;
          if (head.item.start) begin
            prev_x_nxt     = head.item.x;
            prev_y_nxt     = head.item.y;
            acc_nxt        = '0;
            pend_nxt       = '{x: head.item.x, y: head.item.y, tag: head.item.tag,
                               interp: 1'b0, last: 1'b1, trunc: 1'b0};
            pend_valid_nxt = 1'b1;
            state_nxt      = S_FLUSH;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        ax_nxt    = mx[CW-1:0];
        ay_nxt    = my[CW-1:0];
        negx_nxt  = dx[CW];
        negy_nxt  = dy[CW];
        sat_nxt   = mx[CW-1] || my[CW-1];
        len_nxt   = spdr_pkg::LEN_SAT;
        state_nxt = (mx[CW-1] || my[CW-1]) ? S_DECIDE : S_SQX;
      end
      S_SQX: begin
        sqx_nxt   = 62'(ax_r[CW-2:0]) * 62'(ax_r[CW-2:0]);
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sqy_nxt   = 62'(ay_r[CW-2:0]) * 62'(ay_r[CW-2:0]);
        state_nxt = S_SQS;
      end
      S_SQS: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          len_nxt   = sq_root;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (total < {2'b00, min_spacing}) begin
          outcome_nxt = OC_DROP;
          acc_nxt     = total[spdr_pkg::REG_W-1:0];
          prev_x_nxt  = cur_x_r;
          prev_y_nxt  = cur_y_r;
        end else if (total >= {2'b00, max_gap}) begin
          outcome_nxt = OC_COPY;
          acc_nxt     = '0;
          prev_x_nxt  = cur_x_r;
          prev_y_nxt  = cur_y_r;
        end else if (run_n_r >= spdr_pkg::RUN_W'(spdr_pkg::MAX_RUN - 1)) begin
          outcome_nxt = OC_TRUNC;
          acc_nxt     = '0;
          prev_x_nxt  = cur_x_r;
          prev_y_nxt  = cur_y_r;
        end else begin
          outcome_nxt = OC_INTERP;
          rem_nxt     = (min_spacing > acc_r) ? min_spacing - acc_r : '0;
        end
        if (pend_valid_r) begin
          // A held interpolated point is final only if this retry drops.
          pend_nxt.last = (total < {2'b00, min_spacing});
          state_nxt     = S_FLUSH;
        end else if (total < {2'b00, min_spacing}) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ACT;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_nxt        = pend_r;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = pend_r.last ? S_IDLE : S_ACT;
        end
      end
      S_ACT: begin
        case (outcome_r)
          OC_COPY, OC_TRUNC: begin
            pend_nxt       = '{x: cur_x_r, y: cur_y_r, tag: cur_tag_r, interp: 1'b0,
                               last: 1'b1, trunc: (outcome_r == OC_TRUNC)};
            pend_valid_nxt = 1'b1;
            state_nxt      = S_FLUSH;
          end
          OC_INTERP: begin
            if (len_r == '0) begin
              pend_nxt       = '{x: prev_x_r, y: prev_y_r, tag: cur_tag_r, interp: 1'b1,
                                 last: 1'b0, trunc: 1'b0};
              pend_valid_nxt = 1'b1;
              acc_nxt        = '0;
              run_n_nxt      = run_n_r + 1'b1;
              state_nxt      = S_DIFF;
            end else begin
              prx_nxt   = 62'(ax_r[CW-2:0]) * 62'(rem_r);
              pry_nxt   = 62'(ay_r[CW-2:0]) * 62'(rem_r);
              state_nxt = S_MULI;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MULI: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dvx_done && dvy_done) begin
          pend_nxt.x      = negx_r ? prev_x_r - $signed(qx) : prev_x_r + $signed(qx);
          pend_nxt.y      = negy_r ? prev_y_r - $signed(qy) : prev_y_r + $signed(qy);
          pend_nxt.tag    = cur_tag_r;
          pend_nxt.interp = 1'b1;
          pend_nxt.last   = 1'b0;
          pend_nxt.trunc  = 1'b0;
          prev_x_nxt      = negx_r ? prev_x_r - $signed(qx) : prev_x_r + $signed(qx);
          prev_y_nxt      = negy_r ? prev_y_r - $signed(qy) : prev_y_r + $signed(qy);
          pend_valid_nxt  = 1'b1;
          acc_nxt         = '0;
          run_n_nxt       = run_n_r + 1'b1;
          state_nxt       = S_DIFF;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      acc_r        <= '0;
      run_n_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      acc_r        <= acc_nxt;
      run_n_r      <= run_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    cur_tag_r <= cur_tag_nxt;
    rem_r     <= rem_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    negx_r    <= negx_nxt;
    negy_r    <= negy_nxt;
    sat_r     <= sat_nxt;
    len_r     <= len_nxt;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
    prx_r     <= prx_nxt;
    pry_r     <= pry_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  `SPDR_ASSERT_NEXT(a_flush_waits, state_r == S_FLUSH && !out_free, state_r == S_FLUSH)
  `SPDR_ASSERT(a_run_bound, run_n_r <= spdr_pkg::RUN_W'(spdr_pkg::MAX_RUN - 1))
  `SPDR_ASSERT(a_no_sat_interp, (state_r == S_MULI) |-> !sat_r)
  `SPDR_ASSERT(a_idle_no_pend, (state_r == S_IDLE) |-> !pend_valid_r)

endmodule

### src/scan_point_distance_resampler_unit.sv
// Top level of the scan point distance resampler: config registers and wiring.
// Depends on spdr_pkg, spdr_front and spdr_back.
//
//  channel | direction | handshake            | contents
//  in_     | input     | in_tvalid/in_tready  | tdata: pos_x, pos_y, point_tag; tuser: start
//  out_    | output    | out_tvalid/out_tready| tdata: x, y, tag; tuser: interp, trunc; tlast
//  cfg_    | input     | cfg_we               | index 0 min_spacing, index 1 max_gap
//
// A start-of-scan item skips the distance path. Any other item first goes through
// the distance path unless a difference saturates: a difference, the squaring of
// both differences and a 32-step square root. Each interpolated output adds a
// multiply and two parallel 32-step dividers.
// Reset (rst_n low, synchronous) empties the two-entry input queue, the result
// register and the engine, and restores both registers to their defaults.
// The input queue keeps accepting until full while the engine waits on a stalled output.
module scan_point_distance_resampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // pos_x [31:0], pos_y [63:32], point_tag [71:64]
  input  logic        in_tuser,   // start_of_scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_x [31:0], out_y [63:32], out_tag [71:64]
  output logic [1:0]  out_tuser,  // interpolated [0], truncated [1]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [spdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spdr_pkg::REG_W-1:0]     cfg_wdata
);

  logic [spdr_pkg::REG_W-1:0] min_spacing_r, min_spacing_nxt;
  logic [spdr_pkg::REG_W-1:0] max_gap_r, max_gap_nxt;
  logic [spdr_pkg::REG_W-1:0] cfg_val;

  spdr_pkg::item_t       in_item;
  spdr_pkg::queue_head_t head;
  spdr_pkg::result_t     res;
  logic                  pop;

  // A register written as zero behaves as one.
  assign cfg_val = (cfg_wdata == '0) ? spdr_pkg::REG_W'(1) : cfg_wdata;

  always_comb begin
    min_spacing_nxt = min_spacing_r;
    max_gap_nxt     = max_gap_r;
    if (cfg_we) begin
      case (cfg_index)
        spdr_pkg::REG_MIN_SPACING: min_spacing_nxt = cfg_val;
        spdr_pkg::REG_MAX_GAP:     max_gap_nxt     = cfg_val;
        default: begin
          min_spacing_nxt = min_spacing_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_spacing_r <= spdr_pkg::MIN_SPACING_RESET;
      max_gap_r     <= spdr_pkg::MAX_GAP_RESET;
    end else begin
      min_spacing_r <= min_spacing_nxt;
      max_gap_r     <= max_gap_nxt;
    end
  end

  // Unpack the input item; the start flag rides in tuser.
  assign in_item.start = in_tuser;
  assign in_item.x     = in_tdata[31:0];
  assign in_item.y     = in_tdata[63:32];
  assign in_item.tag   = in_tdata[71:64];

  spdr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .head(head), .pop(pop)
  );

  spdr_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .min_spacing(min_spacing_r), .max_gap(max_gap_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.tag, res.y, res.x};
  assign out_tuser = {res.trunc, res.interp};
  assign out_tlast = res.last;

endmodule
